// File: hdl/frt_pkg.sv
// shared types, status codes and helpers for the fragment reassembly tracker
package frt_pkg;

    localparam logic [10:0] LEN_MAX = 11'h7ff;

    typedef enum logic [2:0] {
        ST_DUP       = 3'd0,
        ST_UNFRAG    = 3'd1,
        ST_ACCEPT    = 3'd2,
        ST_NOSLOT    = 3'd3,
        ST_MALFORMED = 3'd4,
        ST_TICK      = 3'd5
    } t_status;

    typedef struct packed {
        logic [15:0] source;
        logic [7:0]  seq_num;
        logic [6:0]  total;
        logic [10:0] byte_count;
        logic [15:0] age;
    } t_slot_meta;

    typedef struct packed {
        t_status     status;
        logic [1:0]  slot;
        logic [15:0] write_offset;
        logic [10:0] write_len;
        logic        complete;
        logic [10:0] complete_len;
        logic [3:0]  expired_mask;
    } t_result;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

// File: hdl/fragment_reassembly_tracker.sv
// top level: header classification and slot sequencer of the fragment reassembly tracker
// o_valid rises when S_DONE hands the result over: empty, unfragmented and malformed headers go
// there straight from idle, ticks after the scan (one slot aged per cycle through a shared incrementer)
// and other fragments after scan, decide, update and 8-bit popcounts; duplicates and no-slot after decide
// ready only when idle, so the next transfer can come at the earliest in the cycle in which o_valid rises
// a result held in the output register stalls the sequencer only at its last step
// reset (synchronous, active low) frees every slot and sets max_age to 128
module fragment_reassembly_tracker
    import frt_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int ORDER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_src_addr,
    input  logic [7:0]  i_type_byte,
    input  logic [7:0]  i_frag_seq,
    input  logic [15:0] i_frag_offset,
    input  logic [10:0] i_packet_len,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [1:0]  o_slot,
    output logic [15:0] o_write_offset,
    output logic [10:0] o_write_len,
    output logic        o_complete,
    output logic [10:0] o_complete_len,
    output logic [3:0]  o_expired_mask
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW     = $clog2(ORDER_BITS);
    localparam int CHUNKS = (ORDER_BITS + 7) / 8;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_COUNT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [15:0]           r_max_age;
    logic                  r_cmd;
    logic [15:0]           r_src;
    logic [7:0]            r_tb;
    logic [7:0]            r_seq;
    logic [15:0]           r_off;
    logic [10:0]           r_plen;
    logic [SW-1:0]         r_idx;
    logic                  r_found;
    logic [SW-1:0]         r_hit;
    logic                  r_free_found;
    logic [SW-1:0]         r_free;
    logic [SW-1:0]         r_target;
    logic                  r_restart;
    logic [SLOTS-1:0]      r_mask;
    logic [ORDER_BITS-1:0] r_bits;
    logic [6:0]            r_total;
    logic [10:0]           r_bc;
    logic [6:0]            r_cnt;
    logic [CW-1:0]         r_chunk;
    t_result               r_res;
    t_result               r_out;
    logic                  r_out_valid;

    logic [SW-1:0]         rd_idx;
    t_slot_meta            rd_meta;
    logic [ORDER_BITS-1:0] rd_bitmap;
    logic                  wr_en;
    t_slot_meta            wr_meta;
    logic [ORDER_BITS-1:0] wr_bitmap;

    logic [5:0]            in_order;
    logic [5:0]            order;
    logic [OW-1:0]         ord_idx;
    logic [ORDER_BITS-1:0] ord_bit;
    logic                  occupied;
    logic [15:0]           age_inc;
    logic                  expire;
    logic [SLOTS-1:0]      n_mask;
    logic [ORDER_BITS-1:0] new_bitmap;
    logic [6:0]            new_total;
    logic [11:0]           bc_sum;
    logic [10:0]           new_bc;
    logic [10:0]           payload;
    logic [6:0]            n_cnt;
    logic                  scan_last;
    logic                  chunk_last;
    logic                  done_hit;
    t_result               hdr_res;
    logic                  hdr_quick;

    frt_slot_table #(
        .SLOTS      (SLOTS),
        .ORDER_BITS (ORDER_BITS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_idx    (rd_idx),
        .o_rd_meta   (rd_meta),
        .o_rd_bitmap (rd_bitmap),
        .i_wr_en     (wr_en),
        .i_wr_idx    (rd_idx),
        .i_wr_meta   (wr_meta),
        .i_wr_bitmap (wr_bitmap)
    );

    assign in_order   = i_type_byte[6:1];
    assign order      = r_tb[6:1];
    assign ord_idx    = order[OW-1:0];
    assign ord_bit    = ORDER_BITS'(1) << ord_idx;
    assign occupied   = (rd_meta.byte_count != '0);
    assign age_inc    = (rd_meta.age == 16'hffff) ? rd_meta.age : rd_meta.age + 16'd1;
    assign expire     = (age_inc >= r_max_age);
    assign n_mask     = r_mask | ((r_cmd && occupied && expire) ? SLOTS'(1) << r_idx : '0);
    assign scan_last  = (r_idx == SW'(SLOTS - 1));
    assign chunk_last = (r_chunk == CW'(CHUNKS - 1));
    assign payload    = r_plen - 11'd4;

    assign new_bitmap = (r_restart ? '0 : rd_bitmap) | ord_bit;
    assign new_total  = r_tb[0] ? (r_restart ? 7'd0 : rd_meta.total) : {1'b0, order} + 7'd1;
    assign bc_sum     = {1'b0, (r_restart ? 11'd0 : rd_meta.byte_count)} + {1'b0, payload};
    assign new_bc     = bc_sum[11] ? LEN_MAX : bc_sum[10:0];
    assign n_cnt      = r_cnt + 7'(popcount8(r_bits[7:0]));
    assign done_hit   = (r_total != '0) && (n_cnt == r_total);

    // headers that finish without touching the slot table
    always_comb begin
        hdr_res   = '0;
        hdr_quick = 1'b0;
        if (!i_cmd) begin
            if (i_packet_len == '0) begin
                hdr_res.status = ST_DUP;
                hdr_quick      = 1'b1;
            end else if (i_type_byte[7:6] == 2'b00) begin
                hdr_res.status    = ST_UNFRAG;
                hdr_res.write_len = i_packet_len - 11'd1;
                hdr_quick         = 1'b1;
            end else if (i_packet_len < 11'd4 || {1'b0, in_order} >= 7'(ORDER_BITS)) begin
                hdr_res.status = ST_MALFORMED;
                hdr_quick      = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_SCAN:   rd_idx = r_idx;
            S_DECIDE: rd_idx = r_found ? r_hit : r_free;
            default:  rd_idx = r_target;
        endcase
    end

    always_comb begin
        wr_en     = 1'b0;
        wr_meta   = rd_meta;
        wr_bitmap = rd_bitmap;
        unique case (r_state)
            S_SCAN: begin
                if (r_cmd && occupied) begin
                    wr_en = 1'b1;
                    if (expire) begin
                        wr_meta.byte_count = '0;
                    end else begin
                        wr_meta.age = age_inc;
                    end
                end
            end
            S_UPDATE: begin
                wr_en              = 1'b1;
                wr_meta.source     = r_src;
                wr_meta.seq_num    = r_seq;
                wr_meta.total      = new_total;
                wr_meta.byte_count = new_bc;
                wr_meta.age        = r_restart ? 16'd0 : rd_meta.age;
                wr_bitmap          = new_bitmap;
            end
            S_COUNT: begin
                if (chunk_last && done_hit) begin
                    wr_en              = 1'b1;
                    wr_meta.byte_count = '0;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_age   <= 16'd128;
        end else begin
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd        <= i_cmd;
                        r_src        <= i_src_addr;
                        r_tb         <= i_type_byte;
                        r_seq        <= i_frag_seq;
                        r_off        <= i_frag_offset;
                        r_plen       <= i_packet_len;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_mask       <= '0;
                        r_res        <= hdr_res;
                        r_state      <= hdr_quick ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx  <= r_idx + SW'(1);
                    r_mask <= n_mask;
                    if (!r_cmd) begin
                        if (occupied && rd_meta.source == r_src && !r_found) begin
                            r_found <= 1'b1;
                            r_hit   <= r_idx;
                        end
                        if (!occupied && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free       <= r_idx;
                        end
                    end
                    if (scan_last) begin
                        if (r_cmd) begin
                            r_res.status       <= ST_TICK;
                            r_res.expired_mask <= 4'(n_mask);
                            r_state            <= S_DONE;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_target <= rd_idx;
                    if (r_found) begin
                        if (rd_meta.seq_num == r_seq) begin
                            r_restart <= 1'b0;
                            if (rd_bitmap[ord_idx]) begin
                                r_res.status <= ST_DUP;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_UPDATE;
                            end
                        end else begin
                            r_restart <= 1'b1;
                            r_state   <= S_UPDATE;
                        end
                    end else if (!r_free_found) begin
                        r_res.status <= ST_NOSLOT;
                        r_state      <= S_DONE;
                    end else begin
                        r_restart <= 1'b1;
                        r_state   <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_bits  <= new_bitmap;
                    r_total <= new_total;
                    r_bc    <= new_bc;
                    r_cnt   <= '0;
                    r_chunk <= '0;
                    r_state <= S_COUNT;
                end
                S_COUNT: begin
                    r_cnt   <= n_cnt;
                    r_bits  <= r_bits >> 8;
                    r_chunk <= r_chunk + CW'(1);
                    if (chunk_last) begin
                        r_res.status       <= ST_ACCEPT;
                        r_res.slot         <= 2'(r_target);
                        r_res.write_offset <= r_off;
                        r_res.write_len    <= payload;
                        r_res.complete     <= done_hit;
                        r_res.complete_len <= done_hit ? r_bc : 11'd0;
                        r_state            <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_slot         = r_out.slot;
    assign o_write_offset = r_out.write_offset;
    assign o_write_len    = r_out.write_len;
    assign o_complete     = r_out.complete;
    assign o_complete_len = r_out.complete_len;
    assign o_expired_mask = r_out.expired_mask;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready while an item is in work");

    a_complete_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_complete) |-> (o_status == ST_ACCEPT))
        else $error("completion flagged on a non-accepted header");

    a_mask_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_expired_mask != 4'd0) |-> (o_status == ST_TICK))
        else $error("expired mask outside a tick result");

    a_slot_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_ACCEPT) |-> (o_slot == 2'd0 && o_write_offset == 16'd0))
        else $error("slot fields set on a non-accepted result");

endmodule

// File: hdl/frt_slot_table.sv
// slot table: per-slot metadata and order bitmap, one read and one write port
module frt_slot_table
    import frt_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int ORDER_BITS = 32,
    localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SW-1:0]         i_rd_idx,
    output t_slot_meta            o_rd_meta,
    output logic [ORDER_BITS-1:0] o_rd_bitmap,
    input  logic                  i_wr_en,
    input  logic [SW-1:0]         i_wr_idx,
    input  t_slot_meta            i_wr_meta,
    input  logic [ORDER_BITS-1:0] i_wr_bitmap
);

    t_slot_meta            r_meta   [SLOTS];
    logic [ORDER_BITS-1:0] r_bitmap [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_meta[i].byte_count <= '0;
            end
        end else if (i_wr_en) begin
            r_meta[i_wr_idx]   <= i_wr_meta;
            r_bitmap[i_wr_idx] <= i_wr_bitmap;
        end
    end

    assign o_rd_meta   = r_meta[i_rd_idx];
    assign o_rd_bitmap = r_bitmap[i_rd_idx];

endmodule
